/* rtl/imu_sample_conditioner_core_assert.svh */
// Assertion macros for the IMU sample conditioner.
// Used by files that check their own control logic; needs clk and rst_n in scope.
`ifndef IMU_SAMPLE_CONDITIONER_CORE_ASSERT_SVH
`define IMU_SAMPLE_CONDITIONER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IMUSC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IMUSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/imusc_pkg.sv */
// Shared types and constants of the IMU sample conditioner.
// No dependencies; imported by every module of the block.
package imusc_pkg;

  localparam int RAW_W    = 16;
  localparam int STATE_W  = 24;
  localparam int ACC_G_W  = 16;
  localparam int RAD_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 24;
  localparam int CFG_W    = 24;
  localparam int MAG_W    = 23;
  localparam int QUO_W    = 16;
  localparam int RND_W    = 8;

  typedef logic signed [RAW_W-1:0]   raw_t;
  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic signed [ACC_G_W-1:0] accel_g_t;
  typedef logic signed [RAD_W-1:0]   rate_rad_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [SCALE_W-1:0]        scale_t;

  typedef enum logic [1:0] {
    ACT_CALIB   = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_CAL_TAKEN  = 2'd0,
    ST_CAL_DONE   = 2'd1,
    ST_MEAS_VALID = 2'd2,
    ST_RESTARTED  = 2'd3
  } status_t;

  typedef enum logic {
    REG_FILTER_GAIN = 1'b0,
    REG_GYRO_SCALE  = 1'b1
  } reg_idx_t;

  localparam gain_t  GAIN_RESET  = 16'd19661;
  localparam scale_t SCALE_RESET = 24'd4570808;

  // rate output clamp, in the width of the shifted product
  localparam logic signed [25:0] RATE_LIMIT = 26'sd4600000;

endpackage

/* rtl/imusc_axis.sv */
// One axis of the measure datapath: accel low-pass step and gyro bias/scale.
// Depends on imusc_pkg.
module imusc_axis (
  input  imusc_pkg::raw_t      accel_raw,
  input  imusc_pkg::raw_t      rate_raw,
  input  imusc_pkg::state_t    filt,
  input  imusc_pkg::state_t    bias,
  input  imusc_pkg::gain_t     gain,
  input  imusc_pkg::scale_t    scale,
  output imusc_pkg::state_t    filt_nxt,
  output imusc_pkg::accel_g_t  accel_g,
  output imusc_pkg::rate_rad_t rate_rad
);
  import imusc_pkg::*;

  logic signed [24:0] acc_scaled;
  logic signed [24:0] diff;
  logic signed [16:0] gain_s;
  logic signed [41:0] filt_prod;
  logic signed [41:0] filt_round;
  logic signed [25:0] step;
  logic signed [25:0] filt_sum;
  logic signed [24:0] g_sum;

  logic signed [24:0] rate_scaled;
  logic signed [24:0] rate_diff;
  logic signed [24:0] scale_s;
  logic signed [49:0] rate_prod;
  logic signed [49:0] rate_round;
  logic signed [25:0] rate_full;

  // filter: state moves toward raw*256 by alpha, rounded to nearest
  assign acc_scaled = $signed({accel_raw[RAW_W-1], accel_raw, 8'd0});
  assign diff       = acc_scaled - $signed({filt[STATE_W-1], filt});
  assign gain_s     = $signed({1'b0, gain});
  assign filt_prod  = 42'(diff) * 42'(gain_s);
  assign filt_round = filt_prod + 42'sd32768;
  assign step       = $signed(filt_round[41:16]);
  assign filt_sum   = $signed({{2{filt[STATE_W-1]}}, filt}) + step;
  assign filt_nxt   = filt_sum[STATE_W-1:0];

  assign g_sum   = $signed({filt_nxt[STATE_W-1], filt_nxt}) + 25'sd128;
  assign accel_g = g_sum[23:8];

  // gyro: remove bias, scale by scale * 2^-24 with rounding, clamp
  assign rate_scaled = $signed({rate_raw[RAW_W-1], rate_raw, 8'd0});
  assign rate_diff   = rate_scaled - $signed({bias[STATE_W-1], bias});
  assign scale_s     = $signed({1'b0, scale});
  assign rate_prod   = 50'(rate_diff) * 50'(scale_s);
  assign rate_round  = rate_prod + 50'sd8388608;
  assign rate_full   = $signed(rate_round[49:24]);

  always_comb begin
    if (rate_full > RATE_LIMIT) begin
      rate_rad = RATE_LIMIT[RAD_W-1:0];
    end else if (rate_full < -RATE_LIMIT) begin
      rate_rad = 24'(-RATE_LIMIT);
    end else begin
      rate_rad = rate_full[RAD_W-1:0];
    end
  end

endmodule

/* rtl/imusc_bias.sv */
// Gyro bias divider: rounds sum*256/CAL_SAMPLES half away from zero.
// Reciprocal multiply on load, remainder and rounding table the cycle after.
// Depends on imusc_pkg.
module imusc_bias #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic              clk,
  input  logic              load,
  input  imusc_pkg::state_t sum,
  output imusc_pkg::state_t bias
);
  import imusc_pkg::*;

  localparam int REM_W       = $clog2(CAL_SAMPLES + 1);
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam longint unsigned RecipVal =
    ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RecipVal);

  logic [STATE_W-1:0] abs_sum;
  logic [MAG_W-1:0]   mag_nxt;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   q_nxt;

  logic [QUO_W-1:0]   q_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_r;

  logic [MAG_W-1:0]   qc;
  logic [MAG_W-1:0]   rem;
  logic [RND_W-1:0]   rnd_tab [2**REM_W];
  logic [STATE_W-1:0] mag_bias;

  // rounding offset for each remainder: floor((512*r + N) / (2*N))
  for (genvar g = 0; g < 2**REM_W; g++) begin : g_rnd
    localparam int RndVal = (512 * g + CAL_SAMPLES) / (2 * CAL_SAMPLES);
    assign rnd_tab[g] = RND_W'(RndVal);
  end

  assign abs_sum = sum[STATE_W-1] ? STATE_W'(-sum) : STATE_W'(sum);
  assign mag_nxt = abs_sum[MAG_W-1:0];
  assign prod    = PROD_W'(mag_nxt) * PROD_W'(RECIP);
  assign q_nxt   = prod[RECIP_SHIFT +: QUO_W];

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= q_nxt;
      mag_r <= mag_nxt;
      neg_r <= sum[STATE_W-1];
    end
  end

  assign qc       = MAG_W'(q_r) * MAG_W'(CAL_SAMPLES);
  assign rem      = mag_r - qc;
  assign mag_bias = {q_r, 8'd0} + STATE_W'(rnd_tab[rem[REM_W-1:0]]);
  assign bias     = neg_r ? $signed(-mag_bias) : $signed(mag_bias);

endmodule

/* rtl/imu_sample_conditioner_core.sv */
// IMU sample conditioner
//
// Input items arrive on in_t* with the action in in_tuser and the six raw axes
// in in_tdata. Each accepted item gives exactly one result item on out_t*:
// status in out_tuser, filtered accel (g, 12 fraction bits) and bias-corrected
// gyro (rad/s, 16 fraction bits) in out_tdata; these are zero for anything but
// a measure item. The user writes filter_gain and gyro_scale on cfg_* only while
// idle; the block itself does not enforce this.
// An item is registered at acceptance and processed into the output register
// when that register is free and no bias settle is pending; its result is on
// out_t* the cycle after it advances. One item is taken per cycle unless the
// output stalls or a bias settle is pending. After the item that completes a
// calibration run the input register holds while the bias divider finishes its
// remainder step. A stalled receiver keeps the result registered and holds the
// input register; in_tready drops only once both are full.
// Reset (rst_n low, synchronous) clears filter state, sums, count, bias, valid
// flags and the pending flag and restores the register defaults.
// Depends on imusc_pkg, imusc_axis, imusc_bias and the assertion macro header.
`include "imu_sample_conditioner_core_assert.svh"

module imu_sample_conditioner_core #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_addr,
  input  logic [23:0]   cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
  input  logic [95:0]   in_tdata,
  // action
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // accel_x_g, accel_y_g, accel_z_g, rate_x_rad, rate_y_rad, rate_z_rad
  output logic [119:0]  out_tdata,
  // status
  output logic [1:0]    out_tuser
);
  import imusc_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

  gain_t   gain_r, gain_nxt;
  scale_t  scale_r, scale_nxt;

  logic    a_valid_r, a_valid_nxt;
  action_t a_action_r;
  raw_t    a_accel_r [3];
  raw_t    a_rate_r [3];

  state_t  filt_r [3];
  state_t  filt_nxt [3];
  state_t  sum_r [3];
  state_t  sum_nxt [3];
  state_t  sum_add [3];
  state_t  bias_r [3];
  state_t  bias_nxt [3];
  state_t  bias_div [3];

  logic [CNT_W-1:0] calib_count_r, calib_count_nxt, count_inc;
  logic    pending_r, pending_nxt;
  logic    cal_finish;
  logic    cal_close;
  logic    bias_load;
  logic    a_advance;
  logic    in_accept;

  state_t    ax_filt [3];
  accel_g_t  ax_g [3];
  rate_rad_t ax_rad [3];

  logic          out_valid_r, out_valid_nxt;
  logic [119:0]  out_data_r, out_data_nxt;
  status_t       out_status_r, status_nxt;

  // hold the input register while the result register is full or the bias settles
  assign a_advance = a_valid_r && (!out_valid_r || out_tready) && !pending_r;
  assign in_tready = !a_valid_r || a_advance;
  assign in_accept = in_tvalid && in_tready;

  assign a_valid_nxt   = in_accept || (a_valid_r && !a_advance);
  assign out_valid_nxt = a_advance || (out_valid_r && !out_tready);

  assign count_inc  = CNT_W'(calib_count_r + 1'b1);
  assign cal_finish = count_inc >= CNT_W'(CAL_SAMPLES);
  assign cal_close  = a_advance && a_action_r == ACT_CALIB && cal_finish;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign sum_add[i] = sum_r[i] + $signed({{(STATE_W-RAW_W){a_rate_r[i][RAW_W-1]}},
                                            a_rate_r[i]});

    imusc_axis u_axis (
      .accel_raw (a_accel_r[i]),
      .rate_raw  (a_rate_r[i]),
      .filt      (filt_r[i]),
      .bias      (bias_r[i]),
      .gain      (gain_r),
      .scale     (scale_r),
      .filt_nxt  (ax_filt[i]),
      .accel_g   (ax_g[i]),
      .rate_rad  (ax_rad[i])
    );

    imusc_bias #(
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_bias (
      .clk  (clk),
      .load (bias_load),
      .sum  (sum_add[i]),
      .bias (bias_div[i])
    );
  end

  always_comb begin
    gain_nxt  = gain_r;
    scale_nxt = scale_r;
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_FILTER_GAIN: gain_nxt  = cfg_wdata[GAIN_W-1:0];
        REG_GYRO_SCALE:  scale_nxt = cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    calib_count_nxt = calib_count_r;
    pending_nxt     = 1'b0;
    bias_load       = 1'b0;
    status_nxt      = ST_RESTARTED;
    out_data_nxt    = '0;
    for (int i = 0; i < 3; i++) begin
      filt_nxt[i] = filt_r[i];
      sum_nxt[i]  = sum_r[i];
      bias_nxt[i] = pending_r ? bias_div[i] : bias_r[i];
    end

    case (a_action_r)
      ACT_CALIB: begin
        status_nxt = cal_finish ? ST_CAL_DONE : ST_CAL_TAKEN;
        if (a_advance) begin
          if (cal_finish) begin
            // close the run: start the divide, drop the sums
            calib_count_nxt = '0;
            pending_nxt     = 1'b1;
            bias_load       = 1'b1;
            for (int i = 0; i < 3; i++) begin
              sum_nxt[i] = '0;
            end
          end else begin
            calib_count_nxt = count_inc;
            for (int i = 0; i < 3; i++) begin
              sum_nxt[i] = sum_add[i];
            end
          end
        end
      end
      ACT_MEASURE: begin
        status_nxt   = ST_MEAS_VALID;
        out_data_nxt = {ax_rad[2], ax_rad[1], ax_rad[0], ax_g[2], ax_g[1], ax_g[0]};
        if (a_advance) begin
          for (int i = 0; i < 3; i++) begin
            filt_nxt[i] = ax_filt[i];
          end
        end
      end
      default: begin
        status_nxt = ST_RESTARTED;
        if (a_advance) begin
          calib_count_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            sum_nxt[i] = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= GAIN_RESET;
      scale_r       <= SCALE_RESET;
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      pending_r     <= 1'b0;
      calib_count_r <= '0;
      for (int i = 0; i < 3; i++) begin
        filt_r[i] <= '0;
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      gain_r        <= gain_nxt;
      scale_r       <= scale_nxt;
      a_valid_r     <= a_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pending_r     <= pending_nxt;
      calib_count_r <= calib_count_nxt;
      for (int i = 0; i < 3; i++) begin
        filt_r[i] <= filt_nxt[i];
        sum_r[i]  <= sum_nxt[i];
        bias_r[i] <= bias_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_action_r <= action_t'(in_tuser);
      for (int i = 0; i < 3; i++) begin
        a_accel_r[i] <= in_tdata[RAW_W*i +: RAW_W];
        a_rate_r[i]  <= in_tdata[RAW_W*(i+3) +: RAW_W];
      end
    end
    if (a_advance) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  `IMUSC_ASSERT_NEXT(a_pending_single, pending_r, !pending_r, "bias settle too long")
  `IMUSC_ASSERT_IMPL(a_pending_holds, pending_r, !a_advance, "advance during bias settle")
  `IMUSC_ASSERT_IMPL(a_count_range, 1'b1, calib_count_r < CNT_W'(CAL_SAMPLES), "count overrun")
  `IMUSC_ASSERT_NEXT(a_finish_pends, cal_close, pending_r && calib_count_r == '0, "no bias load")
  `IMUSC_ASSERT_NEXT(a_result_follows, a_advance, out_valid_r, "advanced item left no result")

endmodule
